// File: sv/ucs2_pkg.sv
// shared types, constants and helpers for the ucs2 hex to utf-8 decoder
`timescale 1ns / 1ps

package ucs2_pkg;

    // capacities above this are clamped
    localparam int unsigned MAX_OUT_BYTES = 4096;
    localparam logic [12:0] CAP_CLAMP =
        (MAX_OUT_BYTES > 8191) ? 13'h1FFF : 13'(MAX_OUT_BYTES);
    localparam logic [12:0] CAPACITY_RESET = 13'd256;

    // default depth of the command queue between front and back
    localparam int unsigned CMD_QUEUE_DEPTH = 4;

    // utf-8 encoding constants
    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [7:0]  LEAD_TWO       = 8'hC0;
    localparam logic [7:0]  LEAD_THREE     = 8'hE0;
    localparam logic [7:0]  CONT_MARK      = 8'h80;
    localparam logic [7:0]  CONT_MASK      = 8'h3F;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_DIGIT = 2'd1,
        STATUS_CAPACITY  = 2'd2
    } status_t;

    // one queued command: the data bytes of an item and an optional terminator
    typedef struct packed {
        logic [1:0]      n_bytes;
        logic [2:0][7:0] bytes;
        logic            term;
        logic [12:0]     count;
        status_t         status;
    } cmd_t;

    // {valid, value} of one ascii hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: r = {1'b1, 4'(c[3:0] + 4'd9)};
            default:       r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/ucs2_front.sv
// front end: digit decode, group assembly, capacity checks and command build
`timescale 1ns / 1ps

module ucs2_front (
    input  logic           clk,
    input  logic           rstn,
    input  logic [12:0]    capacity,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     hex_char,
    input  logic           has_char,
    input  logic           last_char,
    input  logic           queue_full,
    output logic           cmd_push,
    output ucs2_pkg::cmd_t cmd
);

    logic [1:0]  nibble_count_reg, nibble_count_next;
    logic [11:0] code_accum_reg, code_accum_next;
    logic        group_bad_reg, group_bad_next;
    logic [12:0] written_count_reg, written_count_next;
    logic        stopped_reg, stopped_next;
    ucs2_pkg::status_t stop_reason_reg, stop_reason_next;

    logic        accept;
    logic [4:0]  digit;
    logic [15:0] code;
    logic [12:0] cap;
    logic [13:0] w_ext, cap_ext;
    logic        room_group, room_two, room_three, bad;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign digit    = ucs2_pkg::hex_digit(hex_char);
    assign code     = {code_accum_reg, digit[3:0]};
    assign cap      = (32'(capacity) > ucs2_pkg::MAX_OUT_BYTES) ? ucs2_pkg::CAP_CLAMP
                                                                : capacity;
    assign w_ext    = {1'b0, written_count_reg};
    assign cap_ext  = {1'b0, cap};
    // w < cap-4, w+1 < cap-1, w+2 < cap-1 rewritten without negatives
    assign room_group = (w_ext + 14'd4) < cap_ext;
    assign room_two   = (w_ext + 14'd2) < cap_ext;
    assign room_three = (w_ext + 14'd3) < cap_ext;
    assign bad        = group_bad_reg || !digit[4];

    always_comb begin
        nibble_count_next  = nibble_count_reg;
        code_accum_next    = code_accum_reg;
        group_bad_next     = group_bad_reg;
        written_count_next = written_count_reg;
        stopped_next       = stopped_reg;
        stop_reason_next   = stop_reason_reg;
        cmd                = '0;
        cmd.status         = ucs2_pkg::STATUS_OK;

        if (has_char && !stopped_reg) begin
            if (nibble_count_reg != 2'd3) begin
                code_accum_next   = {code_accum_reg[7:0], digit[3:0]};
                nibble_count_next = nibble_count_reg + 2'd1;
                group_bad_next    = bad;
            end else begin
                nibble_count_next = 2'd0;
                code_accum_next   = '0;
                group_bad_next    = 1'b0;
                if (!room_group) begin
                    stopped_next     = 1'b1;
                    stop_reason_next = ucs2_pkg::STATUS_CAPACITY;
                end else if (bad) begin
                    stopped_next     = 1'b1;
                    stop_reason_next = ucs2_pkg::STATUS_BAD_DIGIT;
                end else if (code < ucs2_pkg::ONE_BYTE_LIMIT) begin
                    cmd.n_bytes        = 2'd1;
                    cmd.bytes[0]       = code[7:0];
                    written_count_next = written_count_reg + 13'd1;
                end else if (code < ucs2_pkg::TWO_BYTE_LIMIT) begin
                    if (room_two) begin
                        cmd.n_bytes        = 2'd2;
                        cmd.bytes[0]       = ucs2_pkg::LEAD_TWO | {3'd0, code[10:6]};
                        cmd.bytes[1]       = ucs2_pkg::CONT_MARK
                                           | (code[7:0] & ucs2_pkg::CONT_MASK);
                        written_count_next = written_count_reg + 13'd2;
                    end else begin
                        stopped_next     = 1'b1;
                        stop_reason_next = ucs2_pkg::STATUS_CAPACITY;
                    end
                end else begin
                    if (room_three) begin
                        cmd.n_bytes        = 2'd3;
                        cmd.bytes[0]       = ucs2_pkg::LEAD_THREE | {4'd0, code[15:12]};
                        cmd.bytes[1]       = ucs2_pkg::CONT_MARK
                                           | (code[13:6] & ucs2_pkg::CONT_MASK);
                        cmd.bytes[2]       = ucs2_pkg::CONT_MARK
                                           | (code[7:0] & ucs2_pkg::CONT_MASK);
                        written_count_next = written_count_reg + 13'd3;
                    end else begin
                        stopped_next     = 1'b1;
                        stop_reason_next = ucs2_pkg::STATUS_CAPACITY;
                    end
                end
            end
        end

        if (last_char) begin
            cmd.term   = 1'b1;
            cmd.count  = written_count_next;
            cmd.status = stopped_next ? stop_reason_next : ucs2_pkg::STATUS_OK;
            nibble_count_next  = 2'd0;
            code_accum_next    = '0;
            group_bad_next     = 1'b0;
            written_count_next = '0;
            stopped_next       = 1'b0;
            stop_reason_next   = ucs2_pkg::STATUS_OK;
        end
    end

    assign cmd_push = accept && ((cmd.n_bytes != 2'd0) || cmd.term);

    always_ff @(posedge clk) begin
        if (!rstn) begin
            nibble_count_reg  <= 2'd0;
            code_accum_reg    <= '0;
            group_bad_reg     <= 1'b0;
            written_count_reg <= '0;
            stopped_reg       <= 1'b0;
            stop_reason_reg   <= ucs2_pkg::STATUS_OK;
        end else if (accept) begin
            nibble_count_reg  <= nibble_count_next;
            code_accum_reg    <= code_accum_next;
            group_bad_reg     <= group_bad_next;
            written_count_reg <= written_count_next;
            stopped_reg       <= stopped_next;
            stop_reason_reg   <= stop_reason_next;
        end
    end

endmodule

// File: sv/ucs2_cmd_fifo.sv
// small command queue between the front end and the byte emitter
`timescale 1ns / 1ps

module ucs2_cmd_fifo #(
    parameter int unsigned DEPTH = ucs2_pkg::CMD_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rstn,
    input  logic           push,
    input  ucs2_pkg::cmd_t push_cmd,
    input  logic           pop,
    output ucs2_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ucs2_pkg::cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] level_reg, level_next;

    assign empty = (level_reg == '0);
    assign full  = (level_reg == CNT_W'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/ucs2_back.sv
// back end: walks each queued command out one result beat at a time
`timescale 1ns / 1ps

module ucs2_back (
    input  logic           clk,
    input  logic           rstn,
    input  ucs2_pkg::cmd_t head,
    input  logic           queue_empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_eos,
    output logic [12:0]    out_count,
    output logic [1:0]     out_status
);

    logic [1:0]  beat_idx_reg, beat_idx_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        eos_reg, eos_next;
    logic [12:0] count_reg, count_next;
    logic [1:0]  status_reg, status_next;

    logic       load, is_data, last_beat;
    logic [2:0] total;
    logic [7:0] data_byte;

    assign total     = 3'(head.n_bytes) + 3'(head.term);
    assign is_data   = beat_idx_reg < head.n_bytes;
    assign last_beat = (3'(beat_idx_reg) + 3'd1) == total;
    assign load      = !queue_empty && (!valid_reg || out_ready);
    assign pop       = load && last_beat;

    always_comb begin
        case (beat_idx_reg)
            2'd0:    data_byte = head.bytes[0];
            2'd1:    data_byte = head.bytes[1];
            2'd2:    data_byte = head.bytes[2];
            default: data_byte = 8'd0;
        endcase
    end

    always_comb begin
        beat_idx_next = beat_idx_reg;
        valid_next    = valid_reg && !out_ready;
        byte_next     = byte_reg;
        eos_next      = eos_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        if (load) begin
            beat_idx_next = last_beat ? 2'd0 : beat_idx_reg + 2'd1;
            valid_next    = 1'b1;
            byte_next     = is_data ? data_byte : 8'd0;
            eos_next      = !is_data;
            count_next    = is_data ? 13'd0 : head.count;
            status_next   = is_data ? 2'(ucs2_pkg::STATUS_OK) : 2'(head.status);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            beat_idx_reg <= 2'd0;
            valid_reg    <= 1'b0;
        end else begin
            beat_idx_reg <= beat_idx_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        byte_reg   <= byte_next;
        eos_reg    <= eos_next;
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_eos    = eos_reg;
    assign out_count  = count_reg;
    assign out_status = status_reg;

endmodule

// File: sv/ucs2_hex_to_utf8_decoder.sv
// top level of the ucs2 hex string to utf-8 decoder
`timescale 1ns / 1ps

// Takes an ascii hex string one character per input beat and returns its
// utf-8 form one byte per result beat, closed by a zero terminator beat
// that carries end_of_string, the byte count and a status (0 ok, 1 invalid
// hex digit, 2 output capacity reached). Every four digits make one ucs2
// code point, emitted as 1, 2 or 3 bytes; a trailing partial group is
// dropped. The input side takes one beat every cycle while the command
// queue has room: the front end decodes a character in the cycle it is
// taken and queues the bytes it causes together with any terminator. The
// back end sends one result beat per cycle from its output register while
// the result side is ready; with four characters giving at most three
// bytes, a steady one character per cycle is kept when the result side
// never stalls. out_capacity is written through cfg_we and cfg_wdata,
// resets to 256 and is clamped to MAX_OUT_BYTES; write it only while no
// string is in flight.
module ucs2_hex_to_utf8_decoder #(
    parameter int unsigned CMD_QUEUE_DEPTH = ucs2_pkg::CMD_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // capacity register write
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    // character beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_hex_char,
    input  logic        s_has_char,
    input  logic        s_last_char,
    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_end_of_string,
    output logic [12:0] m_byte_count,
    output logic [1:0]  m_status
);

    logic [12:0] out_capacity_reg;

    ucs2_pkg::cmd_t push_cmd, head_cmd;
    logic           cmd_push, cmd_pop, queue_empty, queue_full;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_capacity_reg <= ucs2_pkg::CAPACITY_RESET;
        end else if (cfg_we) begin
            out_capacity_reg <= cfg_wdata;
        end
    end

    // front end: per-string state and command build
    ucs2_front u_front (
        .clk        (aclk),
        .rstn       (aresetn),
        .capacity   (out_capacity_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .hex_char   (s_hex_char),
        .has_char   (s_has_char),
        .last_char  (s_last_char),
        .queue_full (queue_full),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd)
    );

    // decouples the two sides so each can stall on its own
    ucs2_cmd_fifo #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk      (aclk),
        .rstn     (aresetn),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .head     (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // back end: one result beat per cycle while the result side is ready
    ucs2_back u_back (
        .clk         (aclk),
        .rstn        (aresetn),
        .head        (head_cmd),
        .queue_empty (queue_empty),
        .pop         (cmd_pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_byte    (m_out_byte),
        .out_eos     (m_end_of_string),
        .out_count   (m_byte_count),
        .out_status  (m_status)
    );

    // data beats carry no count and no status
    a_data_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_end_of_string) |->
            (m_byte_count == 13'd0 && m_status == 2'(ucs2_pkg::STATUS_OK)))
        else $error("data beat with nonzero count or status");

    // terminator beat is a zero byte
    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_string) |-> (m_out_byte == 8'd0))
        else $error("terminator beat with nonzero byte");

    // bytes written always leave room for the terminator
    a_count_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_string) |->
            (m_byte_count == 13'd0 || m_byte_count < out_capacity_reg))
        else $error("byte count exceeds output capacity");

endmodule

// File: tb/tb.sv
// self-checking testbench for the ucs2 hex string to utf-8 decoder
`timescale 1ns / 1ps

module tb;

    // cycles allowed after the last result before the block counts as idle
    localparam int SETTLE_CYCLES = 8;
    // input beats that carry a character or close a string, wanted from the random part
    localparam int RANDOM_ITEMS  = 260;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_wdata = 13'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_hex_char = 8'd0;
    logic        s_has_char = 1'b0;
    logic        s_last_char = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_end_of_string;
    logic [12:0] m_byte_count;
    logic [1:0]  m_status;

    // one result beat as it should leave the block
    typedef struct {
        logic [7:0]        out_byte;
        logic              eos;
        logic [12:0]       count;
        ucs2_pkg::status_t st;
    } utf8_beat_t;

    // one directed character beat, with its results typed in when typed is set
    typedef struct {
        logic [7:0]        ch;
        logic              has;
        logic              last;
        bit                typed;
        int                n_data;
        logic [7:0]        data [3];
        logic [12:0]       count;
        ucs2_pkg::status_t st;
    } char_row_t;

    // one character of a random string before it is sent
    typedef struct {
        logic [7:0] ch;
        logic       has;
    } char_slot_t;

    utf8_beat_t utf8_expect [$];

    // decoder state as the testbench sees it
    logic [12:0]       dec_cap = 13'd256;
    logic [1:0]        dec_nibbles = 2'd0;
    logic [11:0]       dec_accum = 12'd0;
    bit                dec_bad = 1'b0;
    logic [12:0]       dec_written = 13'd0;
    bit                dec_halted = 1'b0;
    ucs2_pkg::status_t dec_why = ucs2_pkg::STATUS_OK;

    // results of the last predicted character
    utf8_beat_t pred_beats [4];
    int         pred_n;

    bit idle_on = 1'b0;
    int stall_left = 0;
    int errors = 0;
    int beats_sent = 0;
    int random_items = 0;
    int strings_sent = 0;
    int results_seen = 0;
    int cap_stops = 0;
    int digit_stops = 0;

    // directed strings: empty string, a 2-byte form in lower case, 3-byte and
    // 1-byte extremes, a bad digit group with a character after the stop, and
    // a trailing partial group closed by items without a character
    char_row_t dir_rows [23] = '{
        '{8'h5A, 1'b0, 1'b1, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"0",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"0",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"e",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"9",   1'b1, 1'b1, 1'b1, 2, '{8'hC3, 8'hA9, 8'h00}, 13'd2, ucs2_pkg::STATUS_OK},
        '{"F",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"f",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"F",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"F",   1'b1, 1'b0, 1'b1, 3, '{8'hEF, 8'hBF, 8'hBF}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"0",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"0",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"7",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"F",   1'b1, 1'b1, 1'b1, 1, '{8'h7F, 8'h00, 8'h00}, 13'd4, ucs2_pkg::STATUS_OK},
        '{8'h00, 1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"0",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"4",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"1",   1'b1, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 0, '{8'h00, 8'h00, 8'h00}, 13'd0,
          ucs2_pkg::STATUS_BAD_DIGIT},
        '{"0",   1'b1, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"8",   1'b1, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{"0",   1'b1, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{8'hA5, 1'b0, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK},
        '{8'h3C, 1'b0, 1'b1, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 13'd0, ucs2_pkg::STATUS_OK}
    };

    // capacities per random phase: extremes first, clamp, below five, tight fits
    int unsigned cap_plan [11] = '{5, 8191, 0, 4, 3, 4096, 6, 12, 5000, 9, 20};

    ucs2_hex_to_utf8_decoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_hex_char      (s_hex_char),
        .s_has_char      (s_has_char),
        .s_last_char     (s_last_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_end_of_string (m_end_of_string),
        .m_byte_count    (m_byte_count),
        .m_status        (m_status)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // value of an ascii hex digit, -1 when the character is not one
    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        return -1;
    endfunction

    // ascii digit for a nibble, letters in a random case
    function automatic logic [7:0] hex_ascii(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // code point drawn from the 1-, 2- and 3-byte ranges and their borders
    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    task automatic add_data_beat(input logic [7:0] b);
        pred_beats[pred_n] = '{b, 1'b0, 13'd0, ucs2_pkg::STATUS_OK};
        pred_n++;
    endtask

    // works out the results of one accepted character beat
    task automatic decode_char(input logic [7:0] ch, input logic has, input logic last);
        int         d;
        logic [3:0] nib;
        logic [15:0] code;
        int         cap_eff;
        int         w;
        bit         bad;
        pred_n = 0;
        if (has && !dec_halted) begin
            d = hex_value(ch);
            nib = (d < 0) ? 4'h0 : d[3:0];
            if (d < 0) dec_bad = 1'b1;
            if (dec_nibbles < 2'd3) begin
                dec_accum = {dec_accum[7:0], nib};
                dec_nibbles = dec_nibbles + 2'd1;
            end else begin
                code = {dec_accum, nib};
                cap_eff = (dec_cap > ucs2_pkg::MAX_OUT_BYTES)
                        ? int'(ucs2_pkg::MAX_OUT_BYTES) : int'(dec_cap);
                w = int'(dec_written);
                bad = dec_bad;
                dec_nibbles = 2'd0;
                dec_accum = 12'd0;
                dec_bad = 1'b0;
                // signed compares, so capacities below five stop every group
                if (!(w < cap_eff - 4)) begin
                    dec_halted = 1'b1;
                    dec_why = ucs2_pkg::STATUS_CAPACITY;
                end else if (bad) begin
                    dec_halted = 1'b1;
                    dec_why = ucs2_pkg::STATUS_BAD_DIGIT;
                end else if (code < 16'h0080) begin
                    add_data_beat(code[7:0]);
                    dec_written = dec_written + 13'd1;
                end else if (code < 16'h0800) begin
                    if (w + 1 < cap_eff - 1) begin
                        add_data_beat(8'hC0 | 8'(code >> 6));
                        add_data_beat(8'h80 | 8'(code & 16'h003F));
                        dec_written = dec_written + 13'd2;
                    end else begin
                        dec_halted = 1'b1;
                        dec_why = ucs2_pkg::STATUS_CAPACITY;
                    end
                end else begin
                    if (w + 2 < cap_eff - 1) begin
                        add_data_beat(8'hE0 | 8'(code >> 12));
                        add_data_beat(8'h80 | 8'((code >> 6) & 16'h003F));
                        add_data_beat(8'h80 | 8'(code & 16'h003F));
                        dec_written = dec_written + 13'd3;
                    end else begin
                        dec_halted = 1'b1;
                        dec_why = ucs2_pkg::STATUS_CAPACITY;
                    end
                end
            end
        end
        if (last) begin
            pred_beats[pred_n] = '{8'h00, 1'b1, dec_written,
                                   dec_halted ? dec_why : ucs2_pkg::STATUS_OK};
            pred_n++;
            dec_nibbles = 2'd0;
            dec_accum = 12'd0;
            dec_bad = 1'b0;
            dec_written = 13'd0;
            dec_halted = 1'b0;
            dec_why = ucs2_pkg::STATUS_OK;
        end
    endtask

    // drives one character beat and holds it until the block takes it
    task automatic send_beat(input logic [7:0] ch, input logic has, input logic last,
                             input bit push_pred);
        s_valid <= 1'b1;
        s_hex_char <= ch;
        s_has_char <= has;
        s_last_char <= last;
        do @(posedge aclk); while (!s_ready);
        decode_char(ch, has, last);
        if (push_pred) begin
            for (int k = 0; k < pred_n; k++) utf8_expect.push_back(pred_beats[k]);
        end
        beats_sent++;
    endtask

    // random sender gap, only while idle_on is set
    task automatic pace_sender();
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // sender holds off until every expected beat is back and the block settles
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (utf8_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [12:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        dec_cap = value;
    endtask

    // builds one string of whole groups, then breaks it when tidy is clear
    task automatic send_random_string(input bit tidy, input bit mid_pause);
        char_slot_t slots [$];
        char_slot_t slot;
        logic [15:0] cp;
        int groups;
        int last_idx;
        groups = $urandom_range(0, 4);
        for (int g = 0; g < groups; g++) begin
            cp = pick_code_point();
            for (int k = 3; k >= 0; k--) begin
                slot = '{hex_ascii(cp[k*4 +: 4]), 1'b1};
                slots.push_back(slot);
            end
        end
        if (!tidy) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: if (slots.size() > 0)
                        slots[$urandom_range(0, slots.size() - 1)].ch = 8'($urandom_range(0, 255));
                    1: begin
                        slot = '{8'($urandom_range(0, 255)), 1'b0};
                        slots.insert($urandom_range(0, slots.size()), slot);
                    end
                    2: repeat ($urandom_range(1, 3)) if (slots.size() > 0) void'(slots.pop_back());
                    default: repeat ($urandom_range(1, 3)) begin
                        slot = '{8'($urandom_range(0, 255)), 1'b1};
                        slots.push_back(slot);
                    end
                endcase
            end
        end
        // close on the final character or on a separate item without one
        if (slots.size() == 0 || $urandom_range(0, 1) == 0) begin
            slot = '{8'($urandom_range(0, 255)), 1'b0};
            slots.push_back(slot);
        end
        last_idx = slots.size() - 1;
        for (int i = 0; i <= last_idx; i++) begin
            send_beat(slots[i].ch, slots[i].has, i == last_idx, 1'b1);
            if (slots[i].has || i == last_idx) random_items++;
            if (mid_pause && i == 0 && last_idx > 0) wait_drained();
            else if (i != last_idx) pace_sender();
        end
        strings_sent++;
    endtask

    task automatic report_field(input string what, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endtask

    // compares a result beat with the oldest expectation
    task automatic check_beat();
        utf8_beat_t want;
        results_seen++;
        if (utf8_expect.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual byte 0x%0h eos %0b",
                     $time, m_out_byte, m_end_of_string);
        end else begin
            want = utf8_expect.pop_front();
            if (m_out_byte !== want.out_byte) report_field("out_byte", want.out_byte, m_out_byte);
            if (m_end_of_string !== want.eos)
                report_field("end_of_string", want.eos, m_end_of_string);
            if (m_byte_count !== want.count) report_field("byte_count", want.count, m_byte_count);
            if (m_status !== want.st) report_field("status", want.st, m_status);
            if (want.eos && want.st == ucs2_pkg::STATUS_CAPACITY) cap_stops++;
            if (want.eos && want.st == ucs2_pkg::STATUS_BAD_DIGIT) digit_stops++;
        end
    endtask

    // result side: check every accepted beat, start random stalls while idle_on is set
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_beat();
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int p;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed strings at the reset capacity
        idle_on = 1'b1;
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].ch, dir_rows[i].has, dir_rows[i].last, !dir_rows[i].typed);
            if (dir_rows[i].typed) begin
                for (int k = 0; k < dir_rows[i].n_data; k++)
                    utf8_expect.push_back('{dir_rows[i].data[k], 1'b0, 13'd0,
                                            ucs2_pkg::STATUS_OK});
                if (dir_rows[i].last)
                    utf8_expect.push_back('{8'h00, 1'b1, dir_rows[i].count, dir_rows[i].st});
            end
            pace_sender();
        end

        // random phases, each under its own capacity
        p = 0;
        while (p < $size(cap_plan) || random_items < RANDOM_ITEMS) begin
            write_capacity(p < $size(cap_plan) ? 13'(cap_plan[p]) : 13'($urandom_range(5, 40)));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 3)) begin
                // no idling in the closing stretch
                if (random_items > RANDOM_ITEMS - 40 && p >= $size(cap_plan) - 2)
                    idle_on = 1'b0;
                send_random_string($urandom_range(0, 3) != 0, p == 1 && strings_sent % 3 == 0);
                pace_sender();
            end
            p++;
        end

        wait_drained();
        $display("ran %0d character beats in %0d random strings plus directed ones",
                 beats_sent, strings_sent);
        $display("checked %0d result beats, %0d capacity stops, %0d bad digit stops",
                 results_seen, cap_stops, digit_stops);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: ucs2_hex_to_utf8_decoder.f
sv/ucs2_pkg.sv
sv/ucs2_front.sv
sv/ucs2_cmd_fifo.sv
sv/ucs2_back.sv
sv/ucs2_hex_to_utf8_decoder.sv
tb/tb.sv
